FILE: hw/rtl/loo_nearest_neighbor_accuracy_defines.svh
// Assertion macros for the leave-one-out nearest-neighbor accuracy block
`ifndef LOO_NEAREST_NEIGHBOR_ACCURACY_DEFINES_SVH
`define LOO_NEAREST_NEIGHBOR_ACCURACY_DEFINES_SVH

// same-cycle implication
`define NNA_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define NNA_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: hw/rtl/nna_pkg.sv
// Shared types and constants of the nearest-neighbor accuracy block
`default_nettype none
package nna_pkg;
   localparam int MAX_SAMPLES_DEF  = 1024;
   localparam int MAX_FEATURES_DEF = 16;
   localparam int VALUE_BITS_DEF   = 16;

   localparam logic [1:0] ACT_FEATURE = 2'd0;
   localparam logic [1:0] ACT_LABEL   = 2'd1;
   localparam logic [1:0] ACT_RUN     = 2'd2;
   localparam logic [1:0] ACT_UNUSED  = 2'd3;

   localparam logic [1:0] REG_FEATURE_MASK   = 2'd0;
   localparam logic [1:0] REG_INSTANCE_COUNT = 2'd1;
   localparam logic [1:0] REG_FAST_MODE      = 2'd2;
   localparam logic [1:0] REG_WRONG_LIMIT    = 2'd3;

   // control that travels with one feature pair through the distance pipe
   typedef struct packed {
      logic vld;
      logic en;       // feature enabled in mask
      logic first_f;  // first feature of a pair: clear accumulator
      logic last_f;   // last feature: distance complete
      logic first_j;  // first candidate of a row: clear best
   } nna_ctl_type;
endpackage
`default_nettype wire

FILE: hw/rtl/loo_nearest_neighbor_accuracy.sv
// Top level: stream ports, register file and run sequencer
// Load transactions: accepted back to back while the sequencer is idle.
// Run: per sample, its features are paired with those of every other sample through
//   the feature memory's two read ports; then the pipe drains, the labels are read
//   and the row is scored; one result transaction at the end.
// Result sits in an output register; loads are taken while it waits, a run is not.
// Sync active-high reset clears state, rsp valid, config regs; memories are not cleared.
`default_nettype none
module loo_nearest_neighbor_accuracy #(
   parameter int MAX_SAMPLES  = nna_pkg::MAX_SAMPLES_DEF,
   parameter int MAX_FEATURES = nna_pkg::MAX_FEATURES_DEF,
   parameter int VALUE_BITS   = nna_pkg::VALUE_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [9:0] sample_index, [13:10] feature_index, [29:14] feature_value,
   // [33:30] class_label, [39:34] zero
   input  wire logic [39:0] req_tdata,
   // [1:0] action
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [10:0] correct_count, [21:11] wrong_count, [23:22] zero
   output logic [23:0]      rsp_tdata,
   // [0] aborted
   output logic             rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   `include "loo_nearest_neighbor_accuracy_defines.svh"

   localparam int DEPTH  = MAX_SAMPLES * MAX_FEATURES;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W  = $clog2(MAX_SAMPLES);
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int FW     = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int WIDE_W = (CNT_W > 11) ? CNT_W + 1 : 12;
   localparam logic [1:0] DRAIN_LAST = 2'd3;

   typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_LBL, ST_SCORE} state_type;

   // request fields
   logic [9:0]  sidx;
   logic [3:0]  fidx;
   logic [15:0] fval;
   logic [3:0]  flbl;
   assign sidx = req_tdata[9:0];
   assign fidx = req_tdata[13:10];
   assign fval = req_tdata[29:14];
   assign flbl = req_tdata[33:30];

   // configuration registers
   logic [15:0] mask_ff;
   logic [10:0] icount_ff, limit_ff;
   logic        fast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= 16'hFFFF;
         icount_ff <= 11'd2;
         fast_ff   <= 1'b0;
         limit_ff  <= 11'd1024;
      end else if (csr_we) begin
         unique case (csr_index)
            nna_pkg::REG_FEATURE_MASK:   mask_ff   <= csr_wdata;
            nna_pkg::REG_INSTANCE_COUNT: icount_ff <= csr_wdata[10:0];
            nna_pkg::REG_FAST_MODE:      fast_ff   <= csr_wdata[0];
            nna_pkg::REG_WRONG_LIMIT:    limit_ff  <= csr_wdata[10:0];
         endcase
      end
   end

   // sequencer registers
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] n_ff, n_in, i_ff, i_in, j_ff, j_in;
   logic [FW-1:0]    f_ff, f_in;
   logic [1:0]       drain_ff, drain_in;
   logic [10:0]      correct_ff, correct_in, wrong_ff, wrong_in;
   logic             rsp_valid_ff, rsp_valid_in, abort_ff, abort_in;

   logic req_acc, run_acc, load_ok;
   assign req_tready = (state_ff == ST_IDLE) && !(rsp_valid_ff && req_tuser == nna_pkg::ACT_RUN);
   assign req_acc    = req_tvalid && req_tready;
   assign run_acc    = req_acc && req_tuser == nna_pkg::ACT_RUN;

   // clamp instance_count into [2, MAX_SAMPLES]
   logic [WIDE_W-1:0] ic_wide;
   logic [CNT_W-1:0]  n_clamp;
   always_comb begin
      ic_wide = WIDE_W'(icount_ff);
      if (ic_wide < WIDE_W'(2))                n_clamp = CNT_W'(2);
      else if (ic_wide > WIDE_W'(MAX_SAMPLES)) n_clamp = CNT_W'(MAX_SAMPLES);
      else                                     n_clamp = CNT_W'(ic_wide);
   end

   // pair scan: candidate j skips the row sample i
   logic [CNT_W:0]   j_step, j_adv;
   logic [CNT_W-1:0] j_first;
   logic             last_f, last_j;
   nna_pkg::nna_ctl_type ctl;
   always_comb begin
      j_first = (i_ff == '0) ? CNT_W'(1) : '0;
      j_step  = (CNT_W + 1)'(j_ff) + 1'b1;
      j_adv   = (j_step == (CNT_W + 1)'(i_ff)) ? j_step + 1'b1 : j_step;
      last_f  = f_ff == FW'(MAX_FEATURES - 1);
      last_j  = j_adv >= (CNT_W + 1)'(n_ff);
      ctl.vld     = state_ff == ST_SCAN;
      ctl.en      = (32'(f_ff) < 32'd16) && mask_ff[4'(f_ff)];
      ctl.first_f = f_ff == '0;
      ctl.last_f  = last_f;
      ctl.first_j = j_ff == j_first;
   end

   // write path: value sign-extended from 16 bits, kept at VALUE_BITS
   logic              feat_we, lbl_we;
   logic [ADDR_W-1:0] feat_waddr, addr_a, addr_b;
   logic signed [VALUE_BITS-1:0] feat_wdata;
   logic [31:0]       fval_ext;
   always_comb begin
      load_ok    = 32'(sidx) < 32'(MAX_SAMPLES);
      feat_we    = req_acc && req_tuser == nna_pkg::ACT_FEATURE && load_ok
                   && 32'(fidx) < 32'(MAX_FEATURES);
      lbl_we     = req_acc && req_tuser == nna_pkg::ACT_LABEL && load_ok;
      fval_ext   = {{16{fval[15]}}, fval};
      feat_wdata = fval_ext[VALUE_BITS-1:0];
      feat_waddr = ADDR_W'(ADDR_W'(sidx) * ADDR_W'(MAX_FEATURES)) + ADDR_W'(fidx);
      addr_a = ADDR_W'(ADDR_W'(i_ff[IDX_W-1:0]) * ADDR_W'(MAX_FEATURES)) + ADDR_W'(f_ff);
      addr_b = ADDR_W'(ADDR_W'(j_ff[IDX_W-1:0]) * ADDR_W'(MAX_FEATURES)) + ADDR_W'(f_ff);
   end

   logic signed [VALUE_BITS-1:0] rd_a, rd_b;
   logic [3:0]       lbl_a, lbl_b;
   logic [IDX_W-1:0] best_idx;

   nna_store #(
      .MAX_SAMPLES(MAX_SAMPLES), .MAX_FEATURES(MAX_FEATURES), .VALUE_BITS(VALUE_BITS)
   ) u_store (
      .clock       (clock),
      .feat_we     (feat_we),
      .feat_waddr  (feat_waddr),
      .feat_wdata  (feat_wdata),
      .feat_raddr_a(addr_a),
      .feat_raddr_b(addr_b),
      .feat_rdata_a(rd_a),
      .feat_rdata_b(rd_b),
      .lbl_we      (lbl_we),
      .lbl_waddr   (IDX_W'(sidx)),
      .lbl_wdata   (flbl),
      .lbl_raddr_a (i_ff[IDX_W-1:0]),
      .lbl_raddr_b (best_idx),
      .lbl_rdata_a (lbl_a),
      .lbl_rdata_b (lbl_b)
   );

   nna_dist #(
      .MAX_SAMPLES(MAX_SAMPLES), .MAX_FEATURES(MAX_FEATURES), .VALUE_BITS(VALUE_BITS)
   ) u_dist (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .cand    (j_ff[IDX_W-1:0]),
      .feat_a  (rd_a),
      .feat_b  (rd_b),
      .best_idx(best_idx)
   );

   // scoring of one row
   logic        match;
   logic [10:0] wrong_next;
   logic        abort_now;
   always_comb begin
      match      = lbl_a == lbl_b;
      wrong_next = wrong_ff + {10'd0, !match};
      abort_now  = fast_ff && wrong_next > limit_ff;
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      f_in         = f_ff;
      drain_in     = drain_ff;
      correct_in   = correct_ff;
      wrong_in     = wrong_ff;
      abort_in     = abort_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (run_acc) begin
               state_in   = ST_SCAN;
               n_in       = n_clamp;
               i_in       = '0;
               j_in       = CNT_W'(1);
               f_in       = '0;
               correct_in = '0;
               wrong_in   = '0;
            end
         end
         ST_SCAN: begin
            if (!last_f) begin
               f_in = f_ff + 1'b1;
            end else begin
               f_in = '0;
               if (last_j) begin
                  state_in = ST_DRAIN;
                  drain_in = '0;
               end else begin
                  j_in = CNT_W'(j_adv);
               end
            end
         end
         ST_DRAIN: begin
            // wait for the last distance to reach the best register
            drain_in = drain_ff + 1'b1;
            if (drain_ff == DRAIN_LAST) state_in = ST_LBL;
         end
         ST_LBL: state_in = ST_SCORE;
         ST_SCORE: begin
            correct_in = correct_ff + {10'd0, match};
            wrong_in   = wrong_next;
            if (abort_now || i_ff == n_ff - 1'b1) begin
               state_in     = ST_IDLE;
               abort_in     = abort_now;
               rsp_valid_in = 1'b1;
            end else begin
               state_in = ST_SCAN;
               i_in     = i_ff + 1'b1;
               j_in     = '0;
               f_in     = '0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff       <= n_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      f_ff       <= f_in;
      drain_ff   <= drain_in;
      correct_ff <= correct_in;
      wrong_ff   <= wrong_in;
      abort_ff   <= abort_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, wrong_ff, correct_ff};
   assign rsp_tuser  = abort_ff;

   `NNA_ASSERT_NOW(a_no_self_pair, clock, reset, state_ff == ST_SCAN, i_ff != j_ff,
      "sample paired with itself")
   `NNA_ASSERT_NEXT(a_run_starts_scan, clock, reset, run_acc, state_ff == ST_SCAN,
      "run transaction did not start a scan")
   `NNA_ASSERT_NOW(a_abort_needs_fast, clock, reset, rsp_valid_ff && abort_ff, fast_ff,
      "abort without fast mode")
   `NNA_ASSERT_NOW(a_scan_in_range, clock, reset, state_ff == ST_SCAN,
      (j_ff < n_ff) && (i_ff < n_ff), "scan index beyond instance count")
endmodule
`default_nettype wire

FILE: hw/rtl/nna_store.sv
// Feature and label memories, two registered read ports each
`default_nettype none
module nna_store #(
   parameter int MAX_SAMPLES  = nna_pkg::MAX_SAMPLES_DEF,
   parameter int MAX_FEATURES = nna_pkg::MAX_FEATURES_DEF,
   parameter int VALUE_BITS   = nna_pkg::VALUE_BITS_DEF,
   localparam int DEPTH  = MAX_SAMPLES * MAX_FEATURES,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int IDX_W  = $clog2(MAX_SAMPLES)
) (
   input  wire logic                         clock,
   input  wire logic                         feat_we,
   input  wire logic [ADDR_W-1:0]            feat_waddr,
   input  wire logic signed [VALUE_BITS-1:0] feat_wdata,
   input  wire logic [ADDR_W-1:0]            feat_raddr_a,
   input  wire logic [ADDR_W-1:0]            feat_raddr_b,
   output logic signed [VALUE_BITS-1:0]      feat_rdata_a,
   output logic signed [VALUE_BITS-1:0]      feat_rdata_b,
   input  wire logic                         lbl_we,
   input  wire logic [IDX_W-1:0]             lbl_waddr,
   input  wire logic [3:0]                   lbl_wdata,
   input  wire logic [IDX_W-1:0]             lbl_raddr_a,
   input  wire logic [IDX_W-1:0]             lbl_raddr_b,
   output logic [3:0]                        lbl_rdata_a,
   output logic [3:0]                        lbl_rdata_b
);
   logic signed [VALUE_BITS-1:0] feat_mem [DEPTH];
   logic [3:0]                   lbl_mem  [MAX_SAMPLES];

   always_ff @(posedge clock) begin
      if (feat_we) begin
         feat_mem[feat_waddr] <= feat_wdata;
      end
      feat_rdata_a <= feat_mem[feat_raddr_a];
      feat_rdata_b <= feat_mem[feat_raddr_b];
   end

   always_ff @(posedge clock) begin
      if (lbl_we) begin
         lbl_mem[lbl_waddr] <= lbl_wdata;
      end
      lbl_rdata_a <= lbl_mem[lbl_raddr_a];
      lbl_rdata_b <= lbl_mem[lbl_raddr_b];
   end
endmodule
`default_nettype wire

FILE: hw/rtl/nna_dist.sv
// Distance pipeline: difference, square, accumulate, nearest tracking
`default_nettype none
module nna_dist #(
   parameter int MAX_SAMPLES  = nna_pkg::MAX_SAMPLES_DEF,
   parameter int MAX_FEATURES = nna_pkg::MAX_FEATURES_DEF,
   parameter int VALUE_BITS   = nna_pkg::VALUE_BITS_DEF,
   localparam int IDX_W = $clog2(MAX_SAMPLES)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire nna_pkg::nna_ctl_type         ctl,
   input  wire logic [IDX_W-1:0]             cand,
   input  wire logic signed [VALUE_BITS-1:0] feat_a,
   input  wire logic signed [VALUE_BITS-1:0] feat_b,
   output logic [IDX_W-1:0]                  best_idx
);
   localparam int DIFF_W = VALUE_BITS + 1;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int ACC_W  = SQ_W + $clog2(MAX_FEATURES + 1);

   // stage 1 aligns with memory read data
   nna_pkg::nna_ctl_type ctl1_ff, ctl2_ff, ctl3_ff;
   logic [IDX_W-1:0]     cand1_ff, cand2_ff, cand3_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic [SQ_W-1:0]      sq_ff;
   logic [ACC_W-1:0]     acc_ff, best_ff;
   logic [IDX_W-1:0]     best_idx_ff;

   logic signed [DIFF_W-1:0] diff_in;
   logic [SQ_W-1:0]      sq_in;
   logic [ACC_W-1:0]     sum;

   always_comb begin
      diff_in = ctl1_ff.en ? (DIFF_W'(feat_a) - DIFF_W'(feat_b)) : '0;
      sq_in   = SQ_W'($signed(diff_ff) * $signed(diff_ff));
      sum     = (ctl3_ff.first_f ? '0 : acc_ff) + ACC_W'(sq_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else begin
         ctl1_ff <= ctl;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
      cand1_ff <= cand;
      cand2_ff <= cand1_ff;
      cand3_ff <= cand2_ff;
      diff_ff  <= diff_in;
      sq_ff    <= sq_in;
      if (ctl3_ff.vld) begin
         acc_ff <= sum;
         // strict compare: lowest index wins a tie
         if (ctl3_ff.last_f && (ctl3_ff.first_j || sum < best_ff)) begin
            best_ff     <= sum;
            best_idx_ff <= cand3_ff;
         end
      end
   end

   assign best_idx = best_idx_ff;
endmodule
`default_nettype wire

FILE: tb/sv/tb_loo_nearest_neighbor_accuracy.sv
// Testbench for the leave-one-out nearest-neighbor accuracy block: random loads and runs,
// checked against a built-in scoring model.
`default_nettype none
module tb_loo_nearest_neighbor_accuracy;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SAMPLES  = 1024;
   localparam int NUM_FEATURES = 16;
   localparam int LIVE_SAMPLES = 16;     // samples fully loaded up front; runs stay within them
   localparam int ITEM_TARGET  = 1400;
   localparam int STALL_LIMIT  = 40000;  // cycles with no transaction before giving up
   localparam int HOLD_CYCLES  = 8000;   // long receiver hold-off, longer than one full run
   localparam int SETTLE       = 30;     // idle cycles before a register write or the end

   typedef struct {
      logic [1:0]         action;
      logic [9:0]         sample_idx;
      logic [3:0]         feature_idx;
      logic signed [15:0] value;
      logic [3:0]         label;
   } load_item_type;

   typedef struct {
      logic [10:0] correct;
      logic [10:0] wrong;
      logic        aborted;
   } score_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   loo_nearest_neighbor_accuracy dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow copy of the block's stores and registers
   logic signed [15:0] feat_mem [NUM_SAMPLES][NUM_FEATURES];
   logic [3:0]         label_mem [NUM_SAMPLES];
   logic [15:0]        mask_q   = 16'hFFFF;
   logic [10:0]        count_q  = 11'd2;
   logic               fast_q   = 1'b0;
   logic [10:0]        limit_q  = 11'd1024;

   load_item_type pending_q[$];   // transactions waiting for the driver
   score_type     score_q[$];     // scores owed by accepted runs

   int sender_idle_pct = 37;
   int recv_idle_pct   = 84;
   int hold_token      = 0;    // bumped by the sequencer to ask for a long hold-off
   int hold_seen       = 0;
   int hold_left       = 0;
   int items_sent      = 0;
   int runs_scored     = 0;
   int aborted_runs    = 0;
   int errors          = 0;
   int quiet_cycles    = 0;

   function automatic void queue_item(load_item_type it);
      pending_q = {pending_q, it};
   endfunction

   function automatic longint unsigned pair_distance(int a, int b);
      longint unsigned sum;
      longint          d;
      sum = 0;
      for (int f = 0; f < NUM_FEATURES; f++) begin
         if (mask_q[f]) begin
            d = longint'(feat_mem[a][f]) - longint'(feat_mem[b][f]);
            if (d < 0) d = -d;
            sum += longint'(d) * longint'(d);
         end
      end
      return sum;
   endfunction

   // Leave-one-out scoring over the first n samples, with optional early abort.
   function automatic score_type score_run();
      score_type       s;
      int              n, nearest;
      longint unsigned best, d;
      int              correct, wrong;
      n = count_q;
      if (n < 2) n = 2;
      if (n > NUM_SAMPLES) n = NUM_SAMPLES;
      correct = 0;
      wrong = 0;
      s.aborted = 1'b0;
      for (int i = 0; i < n; i++) begin
         nearest = -1;
         best = 0;
         for (int j = 0; j < n; j++) begin
            if (j == i) continue;
            d = pair_distance(i, j);
            // strict compare: lowest index keeps a tie
            if (nearest < 0 || d < best) begin
               nearest = j;
               best = d;
            end
         end
         if (label_mem[i] == label_mem[nearest]) correct++;
         else wrong++;
         if (fast_q && wrong > limit_q) begin
            s.aborted = 1'b1;
            break;
         end
      end
      s.correct = correct[10:0];
      s.wrong = wrong[10:0];
      return s;
   endfunction

   function automatic void apply_item(load_item_type it);
      case (it.action)
         nna_pkg::ACT_FEATURE: feat_mem[it.sample_idx][it.feature_idx] = it.value;
         nna_pkg::ACT_LABEL:   label_mem[it.sample_idx] = it.label;
         nna_pkg::ACT_RUN:     score_q = {score_q, score_run()};
         default: ;   // unused action: ignored, no score
      endcase
   endfunction

   // Driver: advance on acceptance or when idle; the shadow state is updated at acceptance.
   always @(posedge clock) begin
      load_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            apply_item('{req_tuser, req_tdata[9:0], req_tdata[13:10], req_tdata[29:14],
                         req_tdata[33:30]});
            items_sent++;
         end
         if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            it = pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= it.action;
            req_tdata <= {6'b0, it.label, it.value, it.feature_idx, it.sample_idx};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver ready: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_token) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: every score transaction is matched against the oldest owed score.
   always @(posedge clock) begin
      score_type exp_s;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (score_q.size() == 0) begin
            $display("%0t: unexpected score transaction %h/%b", $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            exp_s = score_q.pop_front();
            runs_scored++;
            if (exp_s.aborted) aborted_runs++;
            if (rsp_tdata[10:0] !== exp_s.correct) begin
               $display("%0t: correct_count expected %0d got %0d", $time, exp_s.correct,
                        rsp_tdata[10:0]);
               errors++;
            end
            if (rsp_tdata[21:11] !== exp_s.wrong) begin
               $display("%0t: wrong_count expected %0d got %0d", $time, exp_s.wrong,
                        rsp_tdata[21:11]);
               errors++;
            end
            if (rsp_tuser !== exp_s.aborted) begin
               $display("%0t: aborted expected %0b got %0b", $time, exp_s.aborted, rsp_tuser);
               errors++;
            end
         end
      end
   end

   // Watchdog: any transaction on any port counts as progress.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Value mix: extremes, a tiny range that makes ties likely, and the full range.
   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2, 3, 4: return 16'($signed($urandom_range(2)) - 1);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic load_item_type make_item(logic [1:0] act, int sidx, int fidx);
      load_item_type it;
      it.action = act;
      it.sample_idx = 10'(sidx);
      it.feature_idx = 4'(fidx);
      it.value = pick_value();
      it.label = 4'($urandom);
      return it;
   endfunction

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         nna_pkg::REG_FEATURE_MASK:   mask_q = val;
         nna_pkg::REG_INSTANCE_COUNT: count_q = val[10:0];
         nna_pkg::REG_FAST_MODE:      fast_q = val[0];
         default:                     limit_q = val[10:0];
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Block is idle once nothing is queued, in flight or owed, plus a settle gap.
   // Checked mid-cycle so the driver's and monitor's updates of this edge are seen.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_q.size() != 0 || req_tvalid || score_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(logic [15:0] mask, int n, bit fast, int lim);
      write_reg(nna_pkg::REG_FEATURE_MASK, mask);
      write_reg(nna_pkg::REG_INSTANCE_COUNT, 16'(n));
      write_reg(nna_pkg::REG_FAST_MODE, 16'(fast));
      write_reg(nna_pkg::REG_WRONG_LIMIT, 16'(lim));
      end_writes();
   endtask

   initial begin
      load_item_type it;
      int phase, r;
      logic [15:0] mask;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Load every feature and label of the live samples so no run reads an empty entry.
      for (int s = 0; s < LIVE_SAMPLES; s++) begin
         for (int f = 0; f < NUM_FEATURES; f++)
            queue_item(make_item(nna_pkg::ACT_FEATURE, s, f));
         queue_item(make_item(nna_pkg::ACT_LABEL, s, 0));
      end
      // Directed: field extremes, a duplicate sample for an exact tie, unused action, runs.
      it = make_item(nna_pkg::ACT_LABEL, 1023, 15);
      it.label = 4'hF;
      queue_item(it);
      it = make_item(nna_pkg::ACT_FEATURE, 1023, 15);
      it.value = 16'sh8000;
      queue_item(it);
      it.value = 16'sh7FFF;
      queue_item(it);
      it = make_item(nna_pkg::ACT_UNUSED, 1023, 15);
      queue_item(it);
      queue_item(make_item(nna_pkg::ACT_RUN, 0, 0));
      for (int f = 0; f < NUM_FEATURES; f++) begin
         it = make_item(nna_pkg::ACT_FEATURE, 3, f);
         it.value = 16'sh0000;
         queue_item(it);
         it.sample_idx = 10'd4;
         queue_item(it);
      end
      it = make_item(nna_pkg::ACT_LABEL, 0, 0);
      it.label = 4'h0;
      queue_item(it);
      wait_idle();
      configure(16'hFFFF, LIVE_SAMPLES, 1'b0, 1024);
      queue_item(make_item(nna_pkg::ACT_RUN, 0, 0));
      wait_idle();
      configure(16'h0000, 5, 1'b0, 1024);          // empty mask: all distances tie
      queue_item(make_item(nna_pkg::ACT_RUN, 0, 0));
      wait_idle();
      write_reg(nna_pkg::REG_INSTANCE_COUNT, 16'd1024);  // largest count, replaced before a run
      configure(16'h0001, 0, 1'b1, 0);             // count below two, abort on first miss
      queue_item(make_item(nna_pkg::ACT_RUN, 0, 0));
      wait_idle();
      configure(16'h8000, 1, 1'b1, 0);
      queue_item(make_item(nna_pkg::ACT_RUN, 0, 0));

      // Random phases: new settings, then loads with runs mixed in.
      phase = 0;
      while (items_sent + pending_q.size() < ITEM_TARGET) begin
         wait_idle();
         if (items_sent < ITEM_TARGET / 3) begin
            sender_idle_pct = 37;
            recv_idle_pct = 84;
         end else if (items_sent < 2 * ITEM_TARGET / 3) begin
            sender_idle_pct = 84;
            recv_idle_pct = 37;
         end else begin
            sender_idle_pct = 0;
            recv_idle_pct = 0;
         end
         r = $urandom_range(3);
         mask = (r == 0) ? 16'hFFFF : (r == 1) ? 16'(1 << $urandom_range(15)) : 16'($urandom);
         configure(mask,
                   ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, LIVE_SAMPLES),
                   $urandom_range(1),
                   ($urandom_range(4) == 0) ? 1024 : $urandom_range(6));
         // one phase with many runs queued behind a long receiver hold-off
         if (phase == 8) begin
            hold_token++;
            for (int k = 0; k < 6; k++) queue_item(make_item(nna_pkg::ACT_RUN, 0, 0));
         end
         for (int k = 0; k < 36; k++) begin
            r = $urandom_range(99);
            if (r < 5)
               queue_item(make_item(nna_pkg::ACT_RUN, 0, 0));
            else if (r < 8)
               queue_item(make_item(nna_pkg::ACT_UNUSED, $urandom_range(1023),
                                    $urandom_range(15)));
            else if (r < 18)   // any address, mostly beyond the live samples
               queue_item(make_item(r[0] ? nna_pkg::ACT_LABEL : nna_pkg::ACT_FEATURE,
                                    $urandom_range(1023), $urandom_range(15)));
            else
               queue_item(make_item(r < 30 ? nna_pkg::ACT_LABEL : nna_pkg::ACT_FEATURE,
                                    $urandom_range(LIVE_SAMPLES - 1),
                                    $urandom_range(15)));
         end
         queue_item(make_item(nna_pkg::ACT_RUN, 0, 0));
         phase++;
      end
      wait_idle();

      $display("%0d transactions sent over %0d phases, %0d runs scored (%0d aborted early)",
               items_sent, phase, runs_scored, aborted_runs);
      if (errors == 0 && score_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/nna_pkg.sv
hw/rtl/nna_store.sv
hw/rtl/nna_dist.sv
hw/rtl/loo_nearest_neighbor_accuracy.sv
tb/sv/tb_loo_nearest_neighbor_accuracy.sv
